// File: sv/mlfp_pkg.sv
package mlfp_pkg;

    localparam logic [7:0] START_BYTE_RST    = 8'd2;
    localparam logic [7:0] OPEN_BYTE_RST     = 8'd60;
    localparam logic [7:0] CLOSE_BYTE_RST    = 8'd62;
    localparam logic [7:0] MAX_LEN_RST       = 8'd64;
    localparam logic [7:0] LEN_BIAS          = 8'd2;
    localparam int         OUT_DEPTH_DEF     = 4;
    localparam int         CFG_ADDR_W        = 2;
    localparam int         TDATA_W           = 72;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_BYTE = 2'd0,
        REG_OPEN_BYTE  = 2'd1,
        REG_CLOSE_BYTE = 2'd2,
        REG_MAX_LEN    = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_START  = 3'd1,
        ERR_LENGTH = 3'd2,
        ERR_OPEN   = 3'd3,
        ERR_TRUNC  = 3'd4,
        ERR_CLOSE  = 3'd5
    } t_err;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] check_byte;
        logic [7:0] body_len;
        logic [7:0] message_type;
        logic [7:0] message_id;
        logic [7:0] dest_addr;
        logic [7:0] source_addr;
        logic [2:0] error_code;
        logic       frame_ok;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
        t_kind      kind;
    } t_result;

    typedef struct packed {
        logic    first_vld;
        logic    second_vld;
        t_result first;
        t_result second;
    } t_push;

endpackage

// File: sv/mlfp_parser.sv
module mlfp_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mlfp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [7:0]                       i_cfg_wdata,
    input  logic                             i_accept,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_buffer_end,
    output mlfp_pkg::t_push                  o_push
);
    import mlfp_pkg::*;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_SRC   = 4'd1,
        PH_DST   = 4'd2,
        PH_ID    = 4'd3,
        PH_TYPE  = 4'd4,
        PH_LEN   = 4'd5,
        PH_OPEN  = 4'd6,
        PH_DATA  = 4'd7,
        PH_CLOSE = 4'd8,
        PH_CHECK = 4'd9
    } t_phase;

    logic [7:0] r_start_byte, r_open_byte, r_close_byte, r_max_len;
    t_phase     r_phase, n_phase;
    logic [7:0] r_src, n_src, r_dst, n_dst, r_id, n_id, r_type, n_type;
    logic [7:0] r_len, n_len, r_count, n_count;
    logic       r_dropping, n_dropping;

    t_err       err;
    logic       ok_done;
    logic       pay_vld;
    logic       stat_vld;
    logic [7:0] len_val;
    t_result    pay_res, stat_res;

    always_comb begin
        n_phase    = r_phase;
        n_src      = r_src;
        n_dst      = r_dst;
        n_id       = r_id;
        n_type     = r_type;
        n_len      = r_len;
        n_count    = r_count;
        n_dropping = r_dropping;
        err        = ERR_NONE;
        ok_done    = 1'b0;
        pay_vld    = 1'b0;
        len_val    = i_rx_byte - LEN_BIAS;

        if (!r_dropping) begin
            case (r_phase)
                PH_SRC: begin
                    n_src   = i_rx_byte;
                    n_phase = PH_DST;
                end
                PH_DST: begin
                    n_dst   = i_rx_byte;
                    n_phase = PH_ID;
                end
                PH_ID: begin
                    n_id    = i_rx_byte;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (i_rx_byte < LEN_BIAS || len_val > r_max_len) begin
                        err = ERR_LENGTH;
                    end else begin
                        n_len   = len_val;
                        n_phase = PH_OPEN;
                    end
                end
                PH_OPEN: begin
                    if (i_rx_byte != r_open_byte) begin
                        err = ERR_OPEN;
                    end else begin
                        n_count = '0;
                        n_phase = (r_len == '0) ? PH_CLOSE : PH_DATA;
                    end
                end
                PH_DATA: begin
                    pay_vld = 1'b1;
                    n_count = r_count + 8'd1;
                    if (n_count >= r_len) begin
                        n_phase = PH_CLOSE;
                    end
                end
                PH_CLOSE: begin
                    if (i_buffer_end) begin
                        err = ERR_TRUNC;
                    end else if (i_rx_byte != r_close_byte) begin
                        err = ERR_CLOSE;
                    end else begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    ok_done = 1'b1;
                end
                default: begin
                    n_src   = '0;
                    n_dst   = '0;
                    n_id    = '0;
                    n_type  = '0;
                    n_len   = '0;
                    n_count = '0;
                    if (i_rx_byte != r_start_byte) begin
                        err = ERR_START;
                    end else begin
                        n_phase = PH_SRC;
                    end
                end
            endcase

            if (!ok_done && err == ERR_NONE && i_buffer_end) begin
                err = ERR_TRUNC;
            end
            if (ok_done || err != ERR_NONE) begin
                n_phase    = PH_START;
                n_dropping = !i_buffer_end;
            end
        end else if (i_buffer_end) begin
            n_dropping = 1'b0;
            n_phase    = PH_START;
        end
    end

    assign stat_vld = !r_dropping && (ok_done || err != ERR_NONE);

    always_comb begin
        pay_res               = '0;
        pay_res.kind          = KIND_PAYLOAD;
        pay_res.payload_byte  = i_rx_byte;
        pay_res.payload_index = r_count;

        stat_res              = '0;
        stat_res.kind         = KIND_STATUS;
        stat_res.frame_ok     = ok_done;
        stat_res.error_code   = err;
        stat_res.source_addr  = n_src;
        stat_res.dest_addr    = n_dst;
        stat_res.message_id   = n_id;
        stat_res.message_type = n_type;
        stat_res.body_len     = n_len;
        stat_res.check_byte   = ok_done ? i_rx_byte : 8'd0;
    end

    always_comb begin
        o_push            = '0;
        o_push.first_vld  = i_accept && (pay_vld || stat_vld);
        o_push.second_vld = i_accept && pay_vld && stat_vld;
        o_push.first      = pay_vld ? pay_res : stat_res;
        o_push.second     = stat_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_open_byte  <= OPEN_BYTE_RST;
            r_close_byte <= CLOSE_BYTE_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_START_BYTE: r_start_byte <= i_cfg_wdata;
                REG_OPEN_BYTE:  r_open_byte  <= i_cfg_wdata;
                REG_CLOSE_BYTE: r_close_byte <= i_cfg_wdata;
                REG_MAX_LEN:    r_max_len    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_src      <= '0;
            r_dst      <= '0;
            r_id       <= '0;
            r_type     <= '0;
            r_len      <= '0;
            r_count    <= '0;
            r_dropping <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_src      <= n_src;
            r_dst      <= n_dst;
            r_id       <= n_id;
            r_type     <= n_type;
            r_len      <= n_len;
            r_count    <= n_count;
            r_dropping <= n_dropping;
        end
    end

endmodule

// File: sv/mlfp_out_fifo.sv
module mlfp_out_fifo #(
    parameter int DEPTH = mlfp_pkg::OUT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlfp_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output mlfp_pkg::t_result o_data
);
    import mlfp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr, r_rd, wr_next;
    logic [CW-1:0]  r_count, n_count;
    logic           pop;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_next = f_inc(r_wr);
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_count = r_count - CW'(pop);
        if (i_push.second_vld) begin
            n_wr    = f_inc(wr_next);
            n_count = n_count + CW'(2);
        end else if (i_push.first_vld) begin
            n_wr    = wr_next;
            n_count = n_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first_vld) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.second_vld) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (pop) begin
                r_rd <= f_inc(r_rd);
            end
        end
    end

endmodule

// File: sv/marker_length_frame_parser.sv
// Byte-serial parser for start-byte / length framed packets. One byte is taken
// per cycle on the slave stream (tlast marks the buffer end); the frame state
// updates in that same cycle and its results land in a small output queue of
// OUT_DEPTH entries, so a new byte is taken in every cycle while the queue holds
// at most OUT_DEPTH-2 results. Payload bytes come out as they arrive (tuser 0),
// followed by one status result per frame (tuser 1): frame_ok, or an error code
// (1 bad start, 2 bad length, 3 no open marker, 4 truncated, 5 no close marker).
// Discard the payload of a frame whose status is an error. A payload byte that
// ends the buffer gives two results, which the queue absorbs. Bytes after a
// status are dropped until the buffer ends. Markers and the length limit are set
// through the write port (0 start, 1 open, 2 close, 3 max payload length); write
// them only while the block is idle, which the block itself does not enforce.
module marker_length_frame_parser #(
    parameter int OUT_DEPTH = mlfp_pkg::OUT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mlfp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [7:0]                          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // rx_byte
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // payload_byte, payload_index, frame_ok, error_code, source_addr, dest_addr,
    // message_id, message_type, body_len, check_byte, zero pad
    output logic [mlfp_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic                                m_axis_tuser   // kind
);
    import mlfp_pkg::*;

    t_push   push;
    t_result res;
    logic    room;
    logic    accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    mlfp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_rx_byte    (s_axis_tdata),
        .i_buffer_end (s_axis_tlast),
        .o_push       (push)
    );

    mlfp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {4'd0, res.check_byte, res.body_len, res.message_type,
                           res.message_id, res.dest_addr, res.source_addr,
                           res.error_code, res.frame_ok, res.payload_index,
                           res.payload_byte};

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 210;

    typedef enum logic [3:0] {
        PH_START, PH_SRC, PH_DST, PH_ID, PH_TYPE, PH_LEN, PH_OPEN, PH_DATA, PH_CLOSE, PH_CHECK
    } t_phase;

    typedef struct {
        logic [7:0] val;
        logic       eob;
    } t_item;

    typedef t_item t_buf[$];

    typedef struct {
        logic [7:0] val;
        logic       eob;
        logic       typed;
        t_result    want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [7:0]            i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tuser;

    marker_length_frame_parser u_top (.*);

    // parser mirror: configuration and frame state
    logic [7:0] cfg_start, cfg_open, cfg_close, cfg_max;
    t_phase     ph;
    logic [7:0] cap_src, cap_dst, cap_id, cap_type, cap_len, pay_cnt;
    logic       drop_rest;

    t_result    pending_q[$];
    int         send_idle = 0;
    int         recv_stall = 0;
    int         mismatches = 0;
    int         cycle_cnt = 0;
    int         n_bytes = 0;
    int         n_buffers = 0;
    int         payloads_seen = 0;
    int         status_seen[8];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt, pending_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_result mk_status(t_err code, logic [7:0] src, dst, id, mtype, len,
                                          chk);
        t_result r;
        r = '0;
        r.kind = KIND_STATUS;
        r.frame_ok = (code == ERR_NONE);
        r.error_code = code;
        r.source_addr = src;
        r.dest_addr = dst;
        r.message_id = id;
        r.message_type = mtype;
        r.body_len = len;
        r.check_byte = chk;
        return r;
    endfunction

    function automatic t_result mk_payload(logic [7:0] val, logic [7:0] idx);
        t_result r;
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = val;
        r.payload_index = idx;
        return r;
    endfunction

    function automatic string show(t_result r);
        return $sformatf("kind=%0d byte=%02h idx=%0d ok=%0b err=%0d src=%02h dst=%02h id=%02h %s",
                         r.kind, r.payload_byte, r.payload_index, r.frame_ok, r.error_code,
                         r.source_addr, r.dest_addr, r.message_id,
                         $sformatf("mtype=%02h len=%0d chk=%02h", r.message_type,
                                   r.body_len, r.check_byte));
    endfunction

    task automatic parse_byte(input logic [7:0] val, input logic eob, ref t_result res[$]);
        t_err code;
        logic fin;
        code = ERR_NONE;
        fin = 1'b0;
        if (drop_rest) begin
            if (eob) begin
                drop_rest = 1'b0;
                ph = PH_START;
            end
            return;
        end
        case (ph)
            PH_SRC: begin
                cap_src = val;
                ph = PH_DST;
            end
            PH_DST: begin
                cap_dst = val;
                ph = PH_ID;
            end
            PH_ID: begin
                cap_id = val;
                ph = PH_TYPE;
            end
            PH_TYPE: begin
                cap_type = val;
                ph = PH_LEN;
            end
            PH_LEN: begin
                if (val < LEN_BIAS || val - LEN_BIAS > cfg_max) begin
                    code = ERR_LENGTH;
                end else begin
                    cap_len = val - LEN_BIAS;
                    ph = PH_OPEN;
                end
            end
            PH_OPEN: begin
                if (val != cfg_open) begin
                    code = ERR_OPEN;
                end else begin
                    pay_cnt = '0;
                    ph = (cap_len == 8'd0) ? PH_CLOSE : PH_DATA;
                end
            end
            PH_DATA: begin
                res.push_back(mk_payload(val, pay_cnt));
                pay_cnt = pay_cnt + 8'd1;
                if (pay_cnt >= cap_len) ph = PH_CLOSE;
            end
            PH_CLOSE: begin
                if (eob) code = ERR_TRUNC;
                else if (val != cfg_close) code = ERR_CLOSE;
                else ph = PH_CHECK;
            end
            PH_CHECK: begin
                res.push_back(mk_status(ERR_NONE, cap_src, cap_dst, cap_id, cap_type, cap_len,
                                        val));
                fin = 1'b1;
            end
            default: begin
                {cap_src, cap_dst, cap_id, cap_type, cap_len, pay_cnt} = '0;
                if (val != cfg_start) code = ERR_START;
                else ph = PH_SRC;
            end
        endcase
        if (!fin && code == ERR_NONE && eob) code = ERR_TRUNC;
        if (code != ERR_NONE) begin
            res.push_back(mk_status(code, cap_src, cap_dst, cap_id, cap_type, cap_len, 8'd0));
            fin = 1'b1;
        end
        if (fin) begin
            ph = PH_START;
            drop_rest = !eob;
        end
    endtask

    // call right after the clock rises; returns in the time step in which the byte is accepted
    task automatic send_byte(input logic [7:0] val, input logic eob, input logic typed,
                             input t_result want);
        t_result res[$];
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= val;
        s_axis_tlast <= eob;
        do @(posedge i_clk); while (!s_axis_tready);
        n_bytes++;
        parse_byte(val, eob, res);
        if (typed) pending_q.push_back(want);
        else foreach (res[k]) pending_q.push_back(res[k]);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] st, op, cl, mx);
        t_cfg_reg   idx[4];
        logic [7:0] val[4];
        idx = '{REG_START_BYTE, REG_OPEN_BYTE, REG_CLOSE_BYTE, REG_MAX_LEN};
        val = '{st, op, cl, mx};
        foreach (idx[k]) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= idx[k];
            i_cfg_wdata <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_start = st;
        cfg_open = op;
        cfg_close = cl;
        cfg_max = mx;
    endtask

    // well-formed frames with random content half of the time, the rest broken or noise
    function automatic t_buf make_frame();
        t_buf       q;
        int         mode, plen, cut;
        logic [7:0] hdr, lenb, mark;
        mode = $urandom_range(11);
        if (mode == 11) begin
            repeat ($urandom_range(6, 1)) q.push_back('{8'($urandom), 1'b0});
        end else begin
            plen = ($urandom_range(19) == 0) ? $urandom_range(cfg_max)
                                             : $urandom_range(cfg_max < 8 ? cfg_max : 8);
            hdr = cfg_start;
            if (mode == 6) hdr = cfg_start ^ 8'($urandom_range(255, 1));
            q.push_back('{hdr, 1'b0});
            repeat (4) q.push_back('{8'($urandom), 1'b0});
            lenb = 8'(plen + 2);
            if (mode == 7) begin
                if (cfg_max > 8'd252 || $urandom_range(1) == 0) lenb = 8'($urandom_range(1));
                else lenb = 8'($urandom_range(255, cfg_max + 3));
            end
            q.push_back('{lenb, 1'b0});
            mark = cfg_open;
            if (mode == 8) mark = cfg_open ^ 8'($urandom_range(255, 1));
            q.push_back('{mark, 1'b0});
            repeat (plen) q.push_back('{8'($urandom), 1'b0});
            mark = cfg_close;
            if (mode == 9) mark = cfg_close ^ 8'($urandom_range(255, 1));
            q.push_back('{mark, 1'b0});
            q.push_back('{8'($urandom), 1'b0});
            if (mode == 10) begin
                cut = $urandom_range(q.size() - 2);
                while (q.size() > cut + 1) void'(q.pop_back());
            end else begin
                repeat ($urandom_range(2)) q.push_back('{8'($urandom), 1'b0});
            end
        end
        q[q.size() - 1].eob = 1'b1;
        return q;
    endfunction

    task automatic flag_error(input string why, input t_result want, got,
                              input logic [3:0] pad);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at cycle %0d", why, cycle_cnt);
            $display("  expected %s", show(want));
            $display("  actual   %s pad=%h", show(got), pad);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'({m_axis_tdata[67:0], m_axis_tuser});
            if (pending_q.size() == 0) begin
                flag_error("result with nothing pending", '0, got, m_axis_tdata[71:68]);
            end else begin
                want = pending_q.pop_front();
                if (got !== want || m_axis_tdata[71:68] !== 4'd0) begin
                    flag_error("result mismatch", want, got, m_axis_tdata[71:68]);
                end else if (want.kind == KIND_PAYLOAD) begin
                    payloads_seen++;
                end else begin
                    status_seen[want.error_code]++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    initial begin
        t_row dir_rows[$];
        t_buf frame_q;
        int   sent;
        logic paused;

        dir_rows = '{
            '{8'h00, 1'b1, 1'b1, mk_status(ERR_START, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0)},
            '{8'h02, 1'b1, 1'b1, mk_status(ERR_TRUNC, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0)},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h3C, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h3E, 1'b0, 1'b0, '0},
            '{8'hA5, 1'b0, 1'b1,
              mk_status(ERR_NONE, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'd1, 8'hA5)},
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h11, 1'b0, 1'b0, '0},
            '{8'h22, 1'b0, 1'b0, '0},
            '{8'h33, 1'b0, 1'b0, '0},
            '{8'h44, 1'b0, 1'b0, '0},
            '{8'h43, 1'b1, 1'b1,
              mk_status(ERR_LENGTH, 8'h11, 8'h22, 8'h33, 8'h44, 8'd0, 8'd0)},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h04, 1'b0, 1'b0, '0},
            '{8'h3C, 1'b0, 1'b0, '0},
            '{8'h9A, 1'b1, 1'b0, '0}
        };

        cfg_start = START_BYTE_RST;
        cfg_open = OPEN_BYTE_RST;
        cfg_close = CLOSE_BYTE_RST;
        cfg_max = MAX_LEN_RST;
        ph = PH_START;
        {cap_src, cap_dst, cap_id, cap_type, cap_len, pay_cnt} = '0;
        drop_rest = 1'b0;
        foreach (status_seen[k]) status_seen[k] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_byte(dir_rows[k].val, dir_rows[k].eob, dir_rows[k].typed, dir_rows[k].want);
        end
        n_buffers += 5;
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            repeat (4) @(posedge i_clk);
            case (p % 4)
                0: set_config(8'h00, 8'h00, 8'hFF, 8'd0);
                1: set_config(8'hFF, 8'hFF, 8'h00, 8'd253);
                2: set_config(START_BYTE_RST, OPEN_BYTE_RST, CLOSE_BYTE_RST, MAX_LEN_RST);
                default: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom_range(253)));
            endcase
            case (p % 4)
                0: begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle = 61;
                    recv_stall = 0;
                end
                2: begin
                    send_idle = 0;
                    recv_stall = 61;
                end
                default: begin
                    send_idle = 7;
                    recv_stall = 7;
                end
            endcase
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_BYTES) begin
                frame_q = make_frame();
                n_buffers++;
                foreach (frame_q[k]) send_byte(frame_q[k].val, frame_q[k].eob, 1'b0, '0);
                sent += frame_q.size();
                if (!paused && sent >= PHASE_BYTES / 2) begin
                    // hold off the sender until the output side has drained
                    paused = 1'b1;
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("sent %0d bytes in %0d buffers over 9 settings; got %0d payload bytes, %0d ok",
                 n_bytes, n_buffers, payloads_seen, status_seen[ERR_NONE]);
        $display("errors start=%0d length=%0d open=%0d trunc=%0d close=%0d; mismatches %0d",
                 status_seen[ERR_START], status_seen[ERR_LENGTH], status_seen[ERR_OPEN],
                 status_seen[ERR_TRUNC], status_seen[ERR_CLOSE], mismatches);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
